@@ rtl/mor_pkg.sv @@
// Package for the object reassembly table: field widths, status codes
// and the content type that marks a slide show object.
// No dependencies.
package mor_pkg;

  localparam int unsigned TID_W   = 16;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned SIZE_W  = 28;
  localparam int unsigned KIND_W  = 6;
  localparam int unsigned SUB_W   = 9;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_OUT_W = 4;

  // operation codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BODY   = 1'b1;

  // content type of a slide show object
  localparam logic [KIND_W-1:0] KIND_SLIDE = 6'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_IGNORED  = 2'd0,
    ST_CREATED  = 2'd1,
    ST_STORED   = 2'd2,
    ST_COMPLETE = 2'd3
  } status_e;

endpackage

@@ rtl/mor_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/mot_object_reassembly_table.sv @@
// Object reassembly table: top level with the sequencer, entry store and
// segment mark store. Depends on mor_pkg and mor_ram.
//
// Usage: drive one word on the input ports and raise start while busy is
// low; the word is taken at that edge and busy goes high. The block scans
// all ENTRIES table entries through one compare and age-subtract unit,
// one entry a cycle, then, where the word calls for it, updates the entry
// and the segment mark row of the slot concerned. Exactly one result word
// follows each input word, shown for one cycle with result_valid_o high;
// busy falls in that same cycle. A segment check reads the mark row,
// multiplies out the offset, compares the fit and writes back. One word
// is in flight at a time: a new word is not taken before the result of
// the last one is out. The receiver cannot stall; results are never held.
// Reset clears all entry valid bits, sets the age counter to one and
// clears the slide flag; the stores need no clearing pass, since a mark
// row is zeroed whenever its entry is created.
module mot_object_reassembly_table #(
  parameter int unsigned ENTRIES      = 16,
  parameter int unsigned MAX_SEGMENTS = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [mor_pkg::TID_W-1:0]    transport_id_i,
  input  logic [mor_pkg::IDX_W-1:0]    segment_index_i,
  input  logic [mor_pkg::BYTES_W-1:0]  seg_bytes_i,
  input  logic [mor_pkg::BYTES_W-1:0]  header_bytes_i,
  input  logic [mor_pkg::SIZE_W-1:0]   object_bytes_i,
  input  logic [mor_pkg::KIND_W-1:0]   kind_code_i,
  input  logic [mor_pkg::SUB_W-1:0]    kind_subcode_i,
  input  logic                         final_segment_i,
  output logic                         result_valid_o,
  output logic [mor_pkg::STAT_W-1:0]   status_o,
  output logic [mor_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic                         write_enable_o,
  output logic [mor_pkg::SIZE_W-1:0]   write_offset_o,
  output logic [mor_pkg::BYTES_W-1:0]  write_length_o,
  output logic [mor_pkg::KIND_W-1:0]   done_kind_o,
  output logic [mor_pkg::SUB_W-1:0]    done_subkind_o,
  output logic [mor_pkg::SIZE_W-1:0]   done_bytes_o,
  output logic                         is_slide_o
);

  localparam int unsigned SLOT_W = $clog2(ENTRIES);
  localparam int unsigned SCAN_W = $clog2(ENTRIES + 1);
  localparam int unsigned SIDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [mor_pkg::TID_W-1:0]   tid;
    logic [mor_pkg::AGE_W-1:0]   age;
    logic [mor_pkg::SIZE_W-1:0]  size;
    logic [mor_pkg::KIND_W-1:0]  kind;
    logic [mor_pkg::SUB_W-1:0]   sub;
    logic                        sz_known;
    logic [mor_pkg::BYTES_W-1:0] seg_size;
    logic                        cnt_known;
    logic [CNT_W-1:0]            seg_count;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MRD, S_CHK, S_FIT, S_WB, S_FIN
  } state_e;

  state_e state_q;

  // latched input word
  logic                        op_q;
  logic [mor_pkg::TID_W-1:0]   tid_q;
  logic [mor_pkg::IDX_W-1:0]   idx_in_q;
  logic [mor_pkg::BYTES_W-1:0] sb_q;
  logic [mor_pkg::BYTES_W-1:0] hb_q;
  logic [mor_pkg::SIZE_W-1:0]  ob_q;
  logic [mor_pkg::KIND_W-1:0]  kc_q;
  logic [mor_pkg::SUB_W-1:0]   ks_q;
  logic                        fin_q;

  // table control state
  logic [ENTRIES-1:0]        valid_q;
  logic [mor_pkg::AGE_W-1:0] age_q;
  logic                      slide_seen_q;

  // scan unit
  logic [SCAN_W-1:0]         cnt_q;
  logic                      found_q, free_found_q;
  logic [SLOT_W-1:0]         fslot_q, free_slot_q, old_slot_q;
  logic [mor_pkg::AGE_W-1:0] best_q;
  entry_t                    fent_q;

  // segment work
  entry_t                      ent_q;
  logic                        have_ent_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [mor_pkg::IDX_W-1:0]   seg_idx_q;
  logic [mor_pkg::BYTES_W-1:0] seg_len_q;
  logic                        seg_last_q;
  logic [MAX_SEGMENTS-1:0]     row_q;
  logic [mor_pkg::SIZE_W-1:0]  off_q;
  logic [mor_pkg::STAT_W-1:0]  st_q;
  logic                        we_q, slide_q;

  // store ports
  logic              e_we;
  logic [SLOT_W-1:0] e_waddr, e_raddr;
  entry_t            e_wdata;
  logic [ENT_W-1:0]  e_rdata_raw;
  entry_t            e_rdata;
  logic                    m_we;
  logic [SLOT_W-1:0]       m_addr;
  logic [MAX_SEGMENTS-1:0] m_wdata, m_rdata;

  mor_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata_raw)
  );
  assign e_rdata = entry_t'(e_rdata_raw);

  mor_ram #(.WIDTH(MAX_SEGMENTS), .DEPTH(ENTRIES)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_addr),
    .wdata_i (m_wdata),
    .raddr_i (m_addr),
    .rdata_o (m_rdata)
  );

  // scan step: entry index whose read data is back this cycle
  logic [SLOT_W-1:0]         scan_j;
  logic [mor_pkg::AGE_W-1:0] scan_age;
  assign scan_j   = SLOT_W'(cnt_q - SCAN_W'(1));
  assign scan_age = age_q - e_rdata.age;

  // new entry at creation
  logic [SLOT_W-1:0] new_slot;
  entry_t            new_ent;
  always_comb begin
    new_slot = free_found_q ? free_slot_q : old_slot_q;
    new_ent           = '0;
    new_ent.tid       = tid_q;
    new_ent.age       = age_q;
    new_ent.size      = ob_q;
    new_ent.kind      = kc_q;
    new_ent.sub       = ks_q;
  end

  // segment checks
  logic [SIDX_W-1:0]           sidx;
  logic                        idx_out;
  logic                        known_n;
  logic [mor_pkg::BYTES_W-1:0] size_n;
  logic [mor_pkg::SIZE_W:0]    end_sum;
  logic                        cnt_known_n;
  logic [CNT_W-1:0]            cnt_n;
  logic [MAX_SEGMENTS-1:0]     mask, row_n;
  logic                        complete;
  always_comb begin
    sidx    = seg_idx_q[SIDX_W-1:0];
    idx_out = seg_idx_q >= mor_pkg::IDX_W'(MAX_SEGMENTS);
    known_n = ent_q.sz_known || !seg_last_q;
    size_n  = ent_q.sz_known ? ent_q.seg_size : seg_len_q;
    end_sum = {1'b0, off_q} + (mor_pkg::SIZE_W+1)'(seg_len_q);
    cnt_known_n = ent_q.cnt_known || seg_last_q;
    cnt_n = seg_last_q ? CNT_W'(seg_idx_q) + CNT_W'(1) : ent_q.seg_count;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      mask[i] = CNT_W'(i) < cnt_n;
    end
    row_n = row_q;
    row_n[sidx] = 1'b1;
    complete = cnt_known_n && (&(row_n | ~mask));
  end

  // store port control
  always_comb begin
    e_we    = 1'b0;
    e_waddr = slot_q;
    e_wdata = ent_q;
    e_raddr = SLOT_W'(cnt_q);
    m_we    = 1'b0;
    m_addr  = slot_q;
    m_wdata = '0;
    case (state_q)
      S_DECIDE: begin
        if (op_q == mor_pkg::OP_HEADER && !found_q) begin
          e_we    = 1'b1;
          e_waddr = new_slot;
          e_wdata = new_ent;
          m_we    = 1'b1;
          m_addr  = new_slot;
        end
      end
      S_FIT: begin
        if (end_sum <= {1'b0, ent_q.size}) begin
          m_we    = 1'b1;
          m_wdata = (complete && ent_q.kind == mor_pkg::KIND_SLIDE && slide_seen_q) ?
                    (row_n & ~mask) : row_n;
        end
      end
      S_WB: begin
        e_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = state_q != S_IDLE;

  // sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      age_q          <= mor_pkg::AGE_W'(1);
      slide_seen_q   <= 1'b0;
      result_valid_o <= 1'b0;
      status_o       <= '0;
      slot_o         <= '0;
      write_enable_o <= 1'b0;
      write_offset_o <= '0;
      write_length_o <= '0;
      done_kind_o    <= '0;
      done_subkind_o <= '0;
      done_bytes_o   <= '0;
      is_slide_o     <= 1'b0;
      cnt_q <= '0; found_q <= 1'b0; free_found_q <= 1'b0;
      fslot_q <= '0; free_slot_q <= '0; old_slot_q <= '0; best_q <= '0;
      fent_q <= '0; ent_q <= '0; have_ent_q <= 1'b0; slot_q <= '0;
      seg_idx_q <= '0; seg_len_q <= '0; seg_last_q <= 1'b0; row_q <= '0;
      off_q <= '0; st_q <= '0; we_q <= 1'b0; slide_q <= 1'b0;
      op_q <= 1'b0; tid_q <= '0; idx_in_q <= '0; sb_q <= '0; hb_q <= '0;
      ob_q <= '0; kc_q <= '0; ks_q <= '0; fin_q <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q     <= operation_i;
            tid_q    <= transport_id_i;
            idx_in_q <= segment_index_i;
            sb_q     <= seg_bytes_i;
            hb_q     <= header_bytes_i;
            ob_q     <= object_bytes_i;
            kc_q     <= kind_code_i;
            ks_q     <= kind_subcode_i;
            fin_q    <= final_segment_i;
            cnt_q        <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            have_ent_q   <= 1'b0;
            st_q         <= mor_pkg::ST_IGNORED;
            we_q         <= 1'b0;
            slide_q      <= 1'b0;
            slot_q       <= '0;
            off_q        <= '0;
            state_q      <= S_SCAN;
          end
        end
        // one entry per cycle: key match, first free, oldest
        S_SCAN: begin
          if (cnt_q != '0) begin
            if (valid_q[scan_j] && e_rdata.tid == tid_q && !found_q) begin
              found_q <= 1'b1;
              fslot_q <= scan_j;
              fent_q  <= e_rdata;
            end
            if (!valid_q[scan_j] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_slot_q  <= scan_j;
            end
            if (scan_j == '0 || scan_age > best_q) begin
              best_q     <= scan_age;
              old_slot_q <= scan_j;
            end
          end
          cnt_q <= cnt_q + SCAN_W'(1);
          if (cnt_q == SCAN_W'(ENTRIES)) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op_q == mor_pkg::OP_HEADER) begin
            if (found_q) begin
              have_ent_q <= 1'b1;
              ent_q      <= fent_q;
              slot_q     <= fslot_q;
              state_q    <= S_FIN;
            end else begin
              have_ent_q        <= 1'b1;
              ent_q             <= new_ent;
              slot_q            <= new_slot;
              valid_q[new_slot] <= 1'b1;
              age_q             <= age_q + mor_pkg::AGE_W'(1);
              st_q              <= mor_pkg::ST_CREATED;
              seg_idx_q         <= '0;
              seg_len_q         <= sb_q - hb_q;
              seg_last_q        <= 1'b0;
              state_q <= (!fin_q && sb_q >= hb_q) ? S_MRD : S_FIN;
            end
          end else if (found_q) begin
            have_ent_q <= 1'b1;
            ent_q      <= fent_q;
            slot_q     <= fslot_q;
            seg_idx_q  <= idx_in_q;
            seg_len_q  <= sb_q;
            seg_last_q <= fin_q;
            state_q    <= S_MRD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_MRD: begin
          state_q <= S_CHK;
        end
        // range, mark and segment size checks; offset multiply
        S_CHK: begin
          row_q <= m_rdata;
          if (idx_out || m_rdata[sidx]) begin
            state_q <= S_FIN;
          end else begin
            ent_q.sz_known <= known_n;
            ent_q.seg_size <= size_n;
            off_q <= mor_pkg::SIZE_W'(sidx) * mor_pkg::SIZE_W'(size_n);
            state_q <= known_n ? S_FIT : S_WB;
          end
        end
        // fit check, mark, completion
        S_FIT: begin
          if (end_sum <= {1'b0, ent_q.size}) begin
            ent_q.cnt_known <= cnt_known_n;
            ent_q.seg_count <= cnt_n;
            we_q <= 1'b1;
            st_q <= complete ? mor_pkg::ST_COMPLETE : mor_pkg::ST_STORED;
            if (complete && ent_q.kind == mor_pkg::KIND_SLIDE) begin
              slide_q      <= 1'b1;
              slide_seen_q <= 1'b1;
            end
          end
          state_q <= S_WB;
        end
        S_WB: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          result_valid_o <= 1'b1;
          status_o       <= st_q;
          slot_o         <= have_ent_q ? mor_pkg::SLOT_OUT_W'(slot_q) : '0;
          write_enable_o <= we_q;
          write_offset_o <= we_q ? off_q : '0;
          write_length_o <= we_q ? seg_len_q : '0;
          done_kind_o    <= have_ent_q ? ent_q.kind : '0;
          done_subkind_o <= have_ent_q ? ent_q.sub : '0;
          done_bytes_o   <= have_ent_q ? ent_q.size : '0;
          is_slide_o     <= slide_q;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/mot_object_reassembly_table_tb.sv @@
// Testbench for the object reassembly table: drives header and body words,
// predicts each result word from a model of the entry table, and compares.
// Depends on mor_pkg and the mot_object_reassembly_table RTL.
module mot_object_reassembly_table_tb;

  localparam int unsigned N_SLOTS  = 16;
  localparam int unsigned N_MARKS  = 128;
  localparam int unsigned N_RANDOM = 700;
  localparam int unsigned POOL_SZ  = 24;

  typedef struct packed {
    logic                        op;
    logic [mor_pkg::TID_W-1:0]   tid;
    logic [mor_pkg::IDX_W-1:0]   idx;
    logic [mor_pkg::BYTES_W-1:0] seg_len;
    logic [mor_pkg::BYTES_W-1:0] hdr_len;
    logic [mor_pkg::SIZE_W-1:0]  obj_len;
    logic [mor_pkg::KIND_W-1:0]  kind;
    logic [mor_pkg::SUB_W-1:0]   subkind;
    logic                        last;
  } seg_word_t;

  typedef struct packed {
    logic [mor_pkg::STAT_W-1:0]  status;
    logic [3:0]                  slot;
    logic                        wr_en;
    logic [mor_pkg::SIZE_W-1:0]  wr_off;
    logic [mor_pkg::BYTES_W-1:0] wr_len;
    logic [mor_pkg::KIND_W-1:0]  kind;
    logic [mor_pkg::SUB_W-1:0]   subkind;
    logic [mor_pkg::SIZE_W-1:0]  obj_len;
    logic                        slide;
  } table_word_t;

  logic clk_i, rst_ni, start, busy;
  seg_word_t   drv;
  logic        result_valid_o;
  table_word_t got;

  // result ports
  logic [mor_pkg::STAT_W-1:0]  got_status;
  logic [3:0]                  got_slot;
  logic                        got_wr_en;
  logic [mor_pkg::SIZE_W-1:0]  got_wr_off;
  logic [mor_pkg::BYTES_W-1:0] got_wr_len;
  logic [mor_pkg::KIND_W-1:0]  got_kind;
  logic [mor_pkg::SUB_W-1:0]   got_subkind;
  logic [mor_pkg::SIZE_W-1:0]  got_obj_len;
  logic                        got_slide;

  // entry table model
  logic                       tbl_valid [N_SLOTS];
  logic [31:0]                tbl_age   [N_SLOTS];
  logic [mor_pkg::TID_W-1:0]  tbl_tid   [N_SLOTS];
  logic [mor_pkg::SIZE_W-1:0] tbl_size  [N_SLOTS];
  logic [mor_pkg::KIND_W-1:0] tbl_kind  [N_SLOTS];
  logic [mor_pkg::SUB_W-1:0]  tbl_sub   [N_SLOTS];
  logic [13:0]                tbl_seg_sz[N_SLOTS];
  logic                       tbl_sz_ok [N_SLOTS];
  logic [15:0]                tbl_count [N_SLOTS];
  logic                       tbl_cnt_ok[N_SLOTS];
  logic                       tbl_marks [N_SLOTS][N_MARKS];
  logic [31:0]                age_now;
  logic                       slide_done;

  table_word_t expected_words[$];
  logic [mor_pkg::TID_W-1:0] tid_pool[POOL_SZ];
  int mismatches;
  int next_gap;
  int words_sent;

  mot_object_reassembly_table u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(drv.op), .transport_id_i(drv.tid), .segment_index_i(drv.idx),
    .seg_bytes_i(drv.seg_len), .header_bytes_i(drv.hdr_len),
    .object_bytes_i(drv.obj_len), .kind_code_i(drv.kind),
    .kind_subcode_i(drv.subkind), .final_segment_i(drv.last),
    .result_valid_o(result_valid_o), .status_o(got_status), .slot_o(got_slot),
    .write_enable_o(got_wr_en), .write_offset_o(got_wr_off),
    .write_length_o(got_wr_len), .done_kind_o(got_kind),
    .done_subkind_o(got_subkind), .done_bytes_o(got_obj_len),
    .is_slide_o(got_slide)
  );

  assign got = {got_status, got_slot, got_wr_en, got_wr_off, got_wr_len,
                got_kind, got_subkind, got_obj_len, got_slide};

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Offer one segment to slot s; returns the status it earns.
  function automatic mor_pkg::status_e offer_segment(int s, int unsigned idx,
                                                     int unsigned len, logic last,
                                                     inout table_word_t r);
    logic [63:0] off;
    int unsigned cnt;
    logic whole;
    if (idx >= N_MARKS || tbl_marks[s][idx]) return mor_pkg::ST_IGNORED;
    if (!last && !tbl_sz_ok[s]) begin
      tbl_seg_sz[s] = 14'(len);
      tbl_sz_ok[s] = 1'b1;
    end
    if (!tbl_sz_ok[s]) return mor_pkg::ST_IGNORED;
    off = 64'(idx) * 64'(tbl_seg_sz[s]);
    if (off + 64'(len) > 64'(tbl_size[s])) return mor_pkg::ST_IGNORED;
    tbl_marks[s][idx] = 1'b1;
    if (last) begin
      tbl_count[s] = 16'(idx + 1);
      tbl_cnt_ok[s] = 1'b1;
    end
    r.wr_en = 1'b1;
    r.wr_off = off[mor_pkg::SIZE_W-1:0];
    r.wr_len = len[mor_pkg::BYTES_W-1:0];
    // completion: count known and every segment below it marked
    whole = tbl_cnt_ok[s];
    cnt = 32'(tbl_count[s]);
    for (int i = 0; i < N_MARKS; i++)
      if (i < cnt && !tbl_marks[s][i]) whole = 1'b0;
    if (!whole) return mor_pkg::ST_STORED;
    if (tbl_kind[s] == mor_pkg::KIND_SLIDE) begin
      r.slide = 1'b1;
      if (slide_done)
        for (int i = 0; i < N_MARKS; i++)
          if (i < cnt) tbl_marks[s][i] = 1'b0;
      slide_done = 1'b1;
    end
    return mor_pkg::ST_COMPLETE;
  endfunction

  function automatic table_word_t predict_table(seg_word_t w);
    table_word_t r;
    mor_pkg::status_e st, sr;
    int s;
    logic [31:0] oldest;
    r = '0;
    st = mor_pkg::ST_IGNORED;
    s = -1;
    for (int i = N_SLOTS - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_tid[i] == w.tid) s = i;
    if (w.op == mor_pkg::OP_HEADER) begin
      if (s < 0) begin
        for (int i = N_SLOTS - 1; i >= 0; i--)
          if (!tbl_valid[i]) s = i;
        if (s < 0) begin
          // full table: replace the entry that has waited longest
          s = 0;
          oldest = age_now - tbl_age[0];
          for (int i = 1; i < N_SLOTS; i++)
            if (age_now - tbl_age[i] > oldest) begin
              oldest = age_now - tbl_age[i];
              s = i;
            end
        end
        tbl_valid[s] = 1'b1;
        tbl_age[s] = age_now;
        age_now++;
        tbl_tid[s] = w.tid;
        tbl_size[s] = w.obj_len;
        tbl_kind[s] = w.kind;
        tbl_sub[s] = w.subkind;
        tbl_sz_ok[s] = 1'b0;
        tbl_cnt_ok[s] = 1'b0;
        tbl_seg_sz[s] = '0;
        tbl_count[s] = '0;
        for (int i = 0; i < N_MARKS; i++) tbl_marks[s][i] = 1'b0;
        st = mor_pkg::ST_CREATED;
        if (!w.last && w.seg_len >= w.hdr_len) begin
          sr = offer_segment(s, 0, 32'(w.seg_len) - 32'(w.hdr_len), 1'b0, r);
          if (sr != mor_pkg::ST_IGNORED) st = sr;
        end
      end
    end else if (s >= 0) begin
      st = offer_segment(s, 32'(w.idx), 32'(w.seg_len), w.last, r);
    end
    if (s >= 0) begin
      r.slot = s[3:0];
      r.kind = tbl_kind[s];
      r.subkind = tbl_sub[s];
      r.obj_len = tbl_size[s];
    end
    r.status = st;
    return r;
  endfunction

  // Send one word; it is taken at the first edge where busy is low.
  task automatic send_word(seg_word_t w);
    if (next_gap > 0) begin
      start <= 1'b0;
      repeat (next_gap) @(posedge clk_i);
    end
    start <= 1'b1;
    drv <= w;
    do @(posedge clk_i); while (busy);
    expected_words.push_back(predict_table(w));
    words_sent++;
    // stretches without any gap
    next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endtask

  function automatic seg_word_t hdr(logic [mor_pkg::TID_W-1:0] tid, int unsigned sb,
                                    int unsigned hb, int unsigned ob,
                                    int unsigned kc, logic last);
    seg_word_t w;
    w = '0;
    w.op = mor_pkg::OP_HEADER;
    w.tid = tid;
    w.idx = 15'($urandom);
    w.seg_len = 13'(sb);
    w.hdr_len = 13'(hb);
    w.obj_len = 28'(ob);
    w.kind = 6'(kc);
    w.subkind = 9'($urandom);
    w.last = last;
    return w;
  endfunction

  function automatic seg_word_t body(logic [mor_pkg::TID_W-1:0] tid, int unsigned idx,
                                     int unsigned sb, logic last);
    seg_word_t w;
    w = '0;
    w.op = mor_pkg::OP_BODY;
    w.tid = tid;
    w.idx = 15'(idx);
    w.seg_len = 13'(sb);
    w.hdr_len = 13'($urandom);
    w.obj_len = 28'($urandom);
    w.kind = 6'($urandom);
    w.subkind = 9'($urandom);
    w.last = last;
    return w;
  endfunction

  // directed corner cases
  task automatic test_corners();
    send_word(body(16'h1234, 0, 10, 1'b0));           // unknown id
    send_word(hdr(16'h1234, 5, 9, 100, 1, 1'b0));      // header longer than data
    send_word(hdr(16'h1234, 50, 0, 100, 1, 1'b0));     // known id
    send_word(body(16'h1234, 0, 1, 1'b1));             // final, size unknown
    send_word(body(16'h1234, 128, 10, 1'b0));          // index past marks
    send_word(body(16'h1234, 32767, 10, 1'b0));
    send_word(body(16'h1234, 20, 10, 1'b0));           // learns size, no fit
    send_word(body(16'h1234, 0, 10, 1'b0));            // fits
    send_word(body(16'h1234, 0, 10, 1'b0));            // already marked
    send_word(body(16'h1234, 9, 10, 1'b1));            // final, incomplete
    for (int i = 1; i < 9; i++) send_word(body(16'h1234, i, 10, 1'b0));
    // slide objects: second completion clears the marks
    send_word(hdr(16'hFFFF, 8191, 8191, 0, 2, 1'b0));
    send_word(hdr(16'h0000, 8191, 0, 28'hFFFFFFF, 63, 1'b1));
    send_word(hdr(16'h0001, 20, 10, 15, 2, 1'b0));
    send_word(body(16'h0001, 1, 5, 1'b1));
    send_word(hdr(16'h0002, 20, 10, 15, 2, 1'b0));
    send_word(body(16'h0002, 1, 5, 1'b1));
    send_word(body(16'h0002, 0, 10, 1'b0));
  endtask

  // full table: new ids push out the oldest entries
  task automatic test_eviction();
    for (int i = 0; i < 20; i++)
      send_word(hdr(16'(32'h8000 + i), $urandom_range(0, 40), 20, 1000,
                    $urandom_range(0, 63), 1'($urandom)));
    send_word(body(16'h8000, 0, 10, 1'b0));
    send_word(body(16'h8013, 0, 10, 1'b0));
  endtask

  // one object sent whole, body segments shuffled with some repeats
  task automatic send_object();
    logic [mor_pkg::TID_W-1:0] tid;
    int unsigned ss, n, tail, hb, order[$], k;
    tid = tid_pool[$urandom_range(0, POOL_SZ - 1)];
    ss = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8000) : $urandom_range(1, 60);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 130) : $urandom_range(1, 6);
    tail = $urandom_range(1, ss);
    hb = $urandom_range(0, 8191 - ss);
    send_word(hdr(tid, hb + ss, hb, (n - 1) * ss + tail,
                  ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(0, 63), n == 1));
    for (int i = 1; i < n; i++) order.push_back(i);
    if (n == 1) order.push_back(0);
    order.shuffle();
    foreach (order[i]) begin
      k = order[i];
      send_word(body(tid, k, (k == n - 1) ? tail : ss, k == n - 1));
      if ($urandom_range(0, 9) == 0)
        send_word(body(tid, k, (k == n - 1) ? tail : ss, k == n - 1));
    end
  endtask

  task automatic test_random();
    seg_word_t w;
    int stop_at;
    stop_at = words_sent + N_RANDOM;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        send_object();
      end else begin
        w.op = 1'($urandom_range(0, 1));
        w.tid = ($urandom_range(0, 1) != 0) ? tid_pool[$urandom_range(0, POOL_SZ - 1)]
                                            : 16'($urandom);
        w.idx = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                            : 15'($urandom_range(0, 130));
        w.seg_len = 13'($urandom);
        w.hdr_len = 13'($urandom);
        w.obj_len = 28'($urandom);
        w.kind = 6'($urandom);
        w.subkind = 9'($urandom);
        w.last = 1'($urandom);
        send_word(w);
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        if (got !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p actual %p", expected_words[0], got);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    #3_000_000;
    $display("mot_object_reassembly_table_tb failed");
    $finish;
  end

  initial begin
    int waited;
    start = 1'b0;
    drv = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    next_gap = 0;
    words_sent = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_age[i] = '0;
      tbl_sz_ok[i] = 1'b0;
      tbl_cnt_ok[i] = 1'b0;
      for (int j = 0; j < N_MARKS; j++) tbl_marks[i][j] = 1'b0;
    end
    age_now = 1;
    slide_done = 1'b0;
    foreach (tid_pool[i]) tid_pool[i] = 16'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    test_eviction();
    test_random();

    @(posedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("mot_object_reassembly_table_tb passed");
    end else begin
      $display("mot_object_reassembly_table_tb failed");
    end
    $finish;
  end

endmodule
